// ===== design/rfm_pkg.sv =====
package rfm_pkg;

    localparam int COORD_W   = 9;
    localparam int RADIUS_W  = 8;
    localparam int SIDE_W    = RADIUS_W + 2;
    localparam int SQ_W      = 19;
    localparam int ROOT_W    = 9;

    localparam int SQRT_STEPS      = 9;
    localparam int STEPS_PER_STAGE = 3;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd1;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_state_t;

    // Test bit of restoring square root step i, counting from the top.
    function automatic logic [SQ_W-1:0] sqrt_bit(input int idx);
        return SQ_W'(1) << (2 * (SQRT_STEPS - 1 - idx));
    endfunction

    function automatic sqrt_state_t rfm_sqrt_step(input sqrt_state_t s,
                                                  input logic [SQ_W-1:0] bit_val);
        sqrt_state_t     r;
        logic [SQ_W-1:0] trial;
        trial = s.root + bit_val;
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + bit_val;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

// ===== design/radial_falloff_mask_pixel.sv =====
// Radial falloff mask pixel: for a sprite of side 2*(radius+1), each input word
// carries a row and column; the block returns radius minus the floor distance
// from the sprite center (zero outside the circle), an in_sprite flag that
// clears for coordinates at or beyond the side, and the side itself. One word
// is accepted per clock while s_tready is high, and its result passes through
// seven register stages, the first loading at the accepting edge: a stage for
// the offsets, one for the two 9x9 squares, one for their sum, three for the
// nine-step square root (three steps per stage), and the output register that
// also forms the falloff value. Each stage holds on its own when the one after
// it is full, so bubbles collapse and a stalled output does not block new words
// until the pipe is full. The radius register is written through cfg_wr_en and
// cfg_wr_data: a write of zero is dropped and larger values clip at MAX_RADIUS.
// Write it only while no word is in flight.
module radial_falloff_mask_pixel #(
    parameter int MAX_RADIUS = 200
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [8:0] row_index, [17:9] col_index, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] alpha_value, [16:8] sprite_side, zero pad
    output logic        m_tuser    // [0] in_sprite
);
    import rfm_pkg::*;

    localparam int NS = 7;
    localparam logic [RADIUS_W-1:0] MAX_CLIP =
        (MAX_RADIUS > 255) ? 8'd255 : RADIUS_W'(MAX_RADIUS);

    // Radius register: drop zero writes, clip large ones.
    logic [RADIUS_W-1:0] radius_reg, radius_next;

    always_comb
    begin
        radius_next = radius_reg;
        if (cfg_wr_en && cfg_wr_data != '0)
        begin
            radius_next = (cfg_wr_data > MAX_CLIP) ? MAX_CLIP : cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else
            radius_reg <= radius_next;
    end

    // Sprite geometry from the current radius.
    logic [COORD_W-1:0] fix;
    logic [SIDE_W-1:0]  side;

    assign fix  = {1'b0, radius_reg} + COORD_W'(1);
    assign side = {fix, 1'b0};

    // Per-stage advance: a stage loads when it is empty or its successor loads.
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
            else
                valid_next[k] = valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_tready = en[0];

    // Stage 1: offset the coordinates to the center, flag the sprite bounds.
    logic [COORD_W-1:0] row_in, col_in;
    logic [COORD_W-1:0] dx_next, dy_next;
    logic               inside1_next;
    logic [COORD_W-1:0] dx1_reg, dy1_reg;
    logic               inside1_reg;

    assign row_in = s_tdata[8:0];
    assign col_in = s_tdata[17:9];

    always_comb
    begin
        inside1_next = ({1'b0, row_in} < side) && ({1'b0, col_in} < side);
        dx_next = (row_in >= fix) ? (row_in - fix) : (fix - row_in);
        dy_next = (col_in >= fix) ? (col_in - fix) : (fix - col_in);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx1_reg     <= dx_next;
            dy1_reg     <= dy_next;
            inside1_reg <= inside1_next;
        end
    end

    // Stage 2: square both offsets.
    logic [2*COORD_W-1:0] dxsq2_reg, dysq2_reg;
    logic                 inside2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dxsq2_reg   <= dx1_reg * dx1_reg;
            dysq2_reg   <= dy1_reg * dy1_reg;
            inside2_reg <= inside1_reg;
        end
    end

    // Stage 3: squared distance.
    logic [SQ_W-1:0] sum3_reg;
    logic            inside3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sum3_reg    <= SQ_W'(dxsq2_reg) + SQ_W'(dysq2_reg);
            inside3_reg <= inside2_reg;
        end
    end

    // Stages 4 to 6: floor square root, three steps per stage.
    sqrt_state_t sq4_next, sq5_next, sq6_next;
    sqrt_state_t sq4_reg, sq5_reg, sq6_reg;
    logic        inside4_reg, inside5_reg, inside6_reg;

    always_comb
    begin
        sq4_next.rem  = sum3_reg;
        sq4_next.root = '0;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            sq4_next = rfm_sqrt_step(sq4_next, sqrt_bit(i));
        end
        sq5_next = sq4_reg;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            sq5_next = rfm_sqrt_step(sq5_next, sqrt_bit(STEPS_PER_STAGE + i));
        end
        sq6_next = sq5_reg;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            sq6_next = rfm_sqrt_step(sq6_next, sqrt_bit(2 * STEPS_PER_STAGE + i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sq4_reg     <= sq4_next;
            inside4_reg <= inside3_reg;
        end
        if (en[4])
        begin
            sq5_reg     <= sq5_next;
            inside5_reg <= inside4_reg;
        end
        if (en[5])
        begin
            sq6_reg     <= sq6_next;
            inside6_reg <= inside5_reg;
        end
    end

    // Stage 7: falloff value into the output register.
    logic [ROOT_W-1:0]   root_dist;
    logic [RADIUS_W-1:0] alpha_next;
    logic [RADIUS_W-1:0] alpha7_reg;
    logic                inside7_reg;

    assign root_dist = sq6_reg.root[ROOT_W-1:0];

    always_comb
    begin
        if (inside6_reg && root_dist <= {1'b0, radius_reg})
            alpha_next = radius_reg - root_dist[RADIUS_W-1:0];
        else
            alpha_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            alpha7_reg  <= alpha_next;
            inside7_reg <= inside6_reg;
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {7'd0, side[COORD_W-1:0], alpha7_reg};
    assign m_tuser  = inside7_reg;

`ifndef SYNTH
    // Radius stays in its legal range.
    a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
        radius_reg != '0 && radius_reg <= MAX_CLIP)
        else $error("radius register out of range");

    // Nonzero falloff only inside the sprite.
    a_alpha_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != '0 |-> m_tuser)
        else $error("nonzero alpha outside sprite");

    // Falloff never exceeds the radius.
    a_alpha_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] <= radius_reg)
        else $error("alpha above radius");

    // A full pipe with a stalled output refuses new words.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !m_tready |-> !s_tready)
        else $error("input accepted into full stalled pipe");
`endif

endmodule
